[hdl/clpt_pkg.sv]
// shared widths, payload types and region codes for the closest point block
`timescale 1ns / 1ps
package clpt_pkg;

  localparam int COORD_BITS       = 24;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int DOT_BITS         = 2 * DIFF_BITS + 2;
  localparam int HALF_BITS        = DOT_BITS / 2;
  localparam int WIDE_BITS        = 2 * DOT_BITS + 4;
  localparam int DIST_BITS        = 2 * COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [WEIGHT_BITS-1:0]       wt_t;

  localparam wt_t WEIGHT_ONE = wt_t'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [2:0] {
    RGN_A, RGN_B, RGN_AB, RGN_C, RGN_AC, RGN_BC, RGN_IN, RGN_DEG
  } region_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } in_t;

  typedef struct packed {
    wt_t                  weight_a;
    wt_t                  weight_b;
    wt_t                  weight_c;
    logic [DIST_BITS-1:0] sq_dist;
    logic [2:0]           region;
  } out_t;

  typedef struct packed {
    dot_t d1;
    dot_t d2;
    dot_t d3;
    dot_t d4;
    dot_t d5;
    dot_t d6;
  } dots_t;

  typedef struct packed {
    in_t     pts;
    region_t rgn;
  } side_t;

  typedef struct packed {
    logic [WIDE_BITS-1:0] rem;
    logic [WIDE_BITS-1:0] den;
    wt_t                  q;
  } lane_t;

endpackage

[hdl/clpt_dots.sv]
// edge vectors and the six dot products, three register stages
`timescale 1ns / 1ps
module clpt_dots import clpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_in,
  input  in_t   pts_in,
  output logic  v_out,
  output in_t   pts_out,
  output dots_t dots_out
);

  typedef logic signed [DIFF_BITS-1:0]   diff_t;
  typedef logic signed [2*DIFF_BITS-1:0] prod_t;

  function automatic dot_t sum3(prod_t x, prod_t y, prod_t z);
    return DOT_BITS'(x) + DOT_BITS'(y) + DOT_BITS'(z);
  endfunction

  coord_t p[3], a[3], b[3], c[3];
  diff_t  ab_r[3], ac_r[3], ap_r[3], bp_r[3], cp_r[3];
  prod_t  pr_r[6][3];
  dots_t  dots_r;
  in_t    pts1_r, pts2_r, pts3_r;
  logic [2:0] v_r;

  assign p[0] = pts_in.point_x;    assign p[1] = pts_in.point_y;    assign p[2] = pts_in.point_z;
  assign a[0] = pts_in.corner_a_x; assign a[1] = pts_in.corner_a_y; assign a[2] = pts_in.corner_a_z;
  assign b[0] = pts_in.corner_b_x; assign b[1] = pts_in.corner_b_y; assign b[2] = pts_in.corner_b_z;
  assign c[0] = pts_in.corner_c_x; assign c[1] = pts_in.corner_c_y; assign c[2] = pts_in.corner_c_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab_r[i] <= DIFF_BITS'(b[i]) - DIFF_BITS'(a[i]);
        ac_r[i] <= DIFF_BITS'(c[i]) - DIFF_BITS'(a[i]);
        ap_r[i] <= DIFF_BITS'(p[i]) - DIFF_BITS'(a[i]);
        bp_r[i] <= DIFF_BITS'(p[i]) - DIFF_BITS'(b[i]);
        cp_r[i] <= DIFF_BITS'(p[i]) - DIFF_BITS'(c[i]);
        pr_r[0][i] <= ab_r[i] * ap_r[i];
        pr_r[1][i] <= ac_r[i] * ap_r[i];
        pr_r[2][i] <= ab_r[i] * bp_r[i];
        pr_r[3][i] <= ac_r[i] * bp_r[i];
        pr_r[4][i] <= ab_r[i] * cp_r[i];
        pr_r[5][i] <= ac_r[i] * cp_r[i];
      end
      dots_r.d1 <= sum3(pr_r[0][0], pr_r[0][1], pr_r[0][2]);
      dots_r.d2 <= sum3(pr_r[1][0], pr_r[1][1], pr_r[1][2]);
      dots_r.d3 <= sum3(pr_r[2][0], pr_r[2][1], pr_r[2][2]);
      dots_r.d4 <= sum3(pr_r[3][0], pr_r[3][1], pr_r[3][2]);
      dots_r.d5 <= sum3(pr_r[4][0], pr_r[4][1], pr_r[4][2]);
      dots_r.d6 <= sum3(pr_r[5][0], pr_r[5][1], pr_r[5][2]);
      pts1_r <= pts_in;
      pts2_r <= pts1_r;
      pts3_r <= pts2_r;
    end
  end

  assign v_out    = v_r[2];
  assign pts_out  = pts3_r;
  assign dots_out = dots_r;

endmodule

[hdl/clpt_region.sv]
// wide region products, region select and divider setup, five register stages
`timescale 1ns / 1ps
module clpt_region import clpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_in,
  input  in_t   pts_in,
  input  dots_t dots_in,
  output logic  v_out,
  output side_t side_out,
  output lane_t lane0_out,
  output lane_t lane1_out
);

  typedef struct packed {
    logic [2*HALF_BITS-1:0]        ll;
    logic signed [2*HALF_BITS:0]   lh;
    logic signed [2*HALF_BITS:0]   hl;
    logic signed [2*HALF_BITS-1:0] hh;
  } parts_t;

  function automatic parts_t split_mul(dot_t x, dot_t y);
    parts_t r;
    logic [HALF_BITS-1:0] xl, yl;
    logic signed [HALF_BITS-1:0] xh, yh;
    xl = x[HALF_BITS-1:0];
    yl = y[HALF_BITS-1:0];
    xh = x[DOT_BITS-1:HALF_BITS];
    yh = y[DOT_BITS-1:HALF_BITS];
    r.ll = xl * yl;
    r.lh = $signed({1'b0, xl}) * yh;
    r.hl = xh * $signed({1'b0, yl});
    r.hh = xh * yh;
    return r;
  endfunction

  function automatic wide_t join_mul(parts_t s);
    wide_t hh, mid, ll;
    hh  = WIDE_BITS'(s.hh);
    mid = WIDE_BITS'(s.lh) + WIDE_BITS'(s.hl);
    ll  = WIDE_BITS'(s.ll);
    return (hh <<< (2 * HALF_BITS)) + (mid <<< HALF_BITS) + ll;
  endfunction

  // edge ratio setup: saturated cases leave a zero remainder
  function automatic lane_t lane_init(wide_t num, wide_t den);
    lane_t r;
    if (den <= 0 || num <= 0) begin
      r.rem = '0;
      r.den = WIDE_BITS'(1);
      r.q   = '0;
    end else if (num >= den) begin
      r.rem = '0;
      r.den = den;
      r.q   = WEIGHT_BITS'(1);
    end else begin
      r.rem = num;
      r.den = den;
      r.q   = '0;
    end
    return r;
  endfunction

  parts_t  pp_r[6];
  wide_t   pr_r[6];
  wide_t   va_r, vb_r, vc_r;
  dots_t   dk1_r, dk2_r, dk3_r;
  in_t     pts_r[5];
  region_t rgn_r, rgn5_r;
  wide_t   n0_r, dn0_r, n1_r, dn1_r;
  lane_t   l0_r, l1_r;
  logic [4:0] v_r;

  region_t rgn_c;
  wide_t   n0_c, dn0_c, n1_c, dn1_c, den_c;
  wide_t   w1, w2, w3, w4, w5, w6;

  assign w1 = WIDE_BITS'(dk3_r.d1);
  assign w2 = WIDE_BITS'(dk3_r.d2);
  assign w3 = WIDE_BITS'(dk3_r.d3);
  assign w4 = WIDE_BITS'(dk3_r.d4);
  assign w5 = WIDE_BITS'(dk3_r.d5);
  assign w6 = WIDE_BITS'(dk3_r.d6);
  assign den_c = va_r + vb_r + vc_r;

  // region tests in the usual vertex, edge, interior order
  always_comb begin
    rgn_c = RGN_A;
    n0_c = '0; dn0_c = '0; n1_c = '0; dn1_c = '0;
    if (w1 <= 0 && w2 <= 0) begin
      rgn_c = RGN_A;
    end else if (w3 >= 0 && w4 <= w3) begin
      rgn_c = RGN_B;
    end else if (vc_r <= 0 && w1 >= 0 && w3 <= 0) begin
      rgn_c = RGN_AB;
      n0_c  = w1;
      dn0_c = w1 - w3;
    end else if (w6 >= 0 && w5 <= w6) begin
      rgn_c = RGN_C;
    end else if (vb_r <= 0 && w2 >= 0 && w6 <= 0) begin
      rgn_c = RGN_AC;
      n1_c  = w2;
      dn1_c = w2 - w6;
    end else if (va_r <= 0 && (w4 - w3) >= 0 && (w5 - w6) >= 0) begin
      rgn_c = RGN_BC;
      n1_c  = w4 - w3;
      dn1_c = (w4 - w3) + (w5 - w6);
    end else if (den_c == 0) begin
      rgn_c = RGN_DEG;
    end else begin
      rgn_c = RGN_IN;
      n0_c  = vb_r;
      dn0_c = den_c;
      n1_c  = vc_r;
      dn1_c = den_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= split_mul(dots_in.d1, dots_in.d4);
      pp_r[1] <= split_mul(dots_in.d3, dots_in.d2);
      pp_r[2] <= split_mul(dots_in.d5, dots_in.d2);
      pp_r[3] <= split_mul(dots_in.d1, dots_in.d6);
      pp_r[4] <= split_mul(dots_in.d3, dots_in.d6);
      pp_r[5] <= split_mul(dots_in.d5, dots_in.d4);
      for (int k = 0; k < 6; k++) begin
        pr_r[k] <= join_mul(pp_r[k]);
      end
      vc_r <= pr_r[0] - pr_r[1];
      vb_r <= pr_r[2] - pr_r[3];
      va_r <= pr_r[4] - pr_r[5];
      rgn_r <= rgn_c;
      n0_r  <= n0_c;
      dn0_r <= dn0_c;
      n1_r  <= n1_c;
      dn1_r <= dn1_c;
      l0_r   <= lane_init(n0_r, dn0_r);
      l1_r   <= lane_init(n1_r, dn1_r);
      rgn5_r <= rgn_r;
      dk1_r <= dots_in;
      dk2_r <= dk1_r;
      dk3_r <= dk2_r;
      pts_r[0] <= pts_in;
      for (int k = 1; k < 5; k++) begin
        pts_r[k] <= pts_r[k-1];
      end
    end
  end

  assign v_out     = v_r[4];
  assign side_out  = '{pts: pts_r[4], rgn: rgn5_r};
  assign lane0_out = l0_r;
  assign lane1_out = l1_r;

endmodule

[hdl/clpt_div.sv]
// two-lane restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps
module clpt_div import clpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_in,
  input  side_t side_in,
  input  lane_t lane0_in,
  input  lane_t lane1_in,
  output logic  v_out,
  output side_t side_out,
  output wt_t   q0_out,
  output wt_t   q1_out
);

  localparam int LAST = WEIGHT_FRAC_BITS - 1;

  function automatic lane_t step(lane_t x);
    lane_t r;
    logic [WIDE_BITS:0] r2, d2;
    r2 = {x.rem, 1'b0};
    d2 = {1'b0, x.den};
    r.den = x.den;
    if (r2 >= d2) begin
      r.rem = WIDE_BITS'(r2 - d2);
      r.q   = {x.q[WEIGHT_BITS-2:0], 1'b1};
    end else begin
      r.rem = r2[WIDE_BITS-1:0];
      r.q   = {x.q[WEIGHT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  lane_t l0_r[WEIGHT_FRAC_BITS];
  lane_t l1_r[WEIGHT_FRAC_BITS];
  side_t side_r[WEIGHT_FRAC_BITS];
  logic [WEIGHT_FRAC_BITS-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[WEIGHT_FRAC_BITS-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_r[0]   <= step(lane0_in);
      l1_r[0]   <= step(lane1_in);
      side_r[0] <= side_in;
      for (int k = 1; k < WEIGHT_FRAC_BITS; k++) begin
        l0_r[k]   <= step(l0_r[k-1]);
        l1_r[k]   <= step(l1_r[k-1]);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign v_out    = v_r[LAST];
  assign side_out = side_r[LAST];
  assign q0_out   = l0_r[LAST].q;
  assign q1_out   = l1_r[LAST].q;

endmodule

[hdl/clpt_dist.sv]
// final weights, closest point and squared distance, six register stages
`timescale 1ns / 1ps
module clpt_dist import clpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_in,
  input  side_t side_in,
  input  wt_t   q0_in,
  input  wt_t   q1_in,
  output logic  v_out,
  output out_t  res_out
);

  localparam int MUL_BITS = COORD_BITS + WEIGHT_BITS + 1;
  localparam int SUM_BITS = MUL_BITS + 2;
  localparam int DD_BITS  = COORD_BITS + 2;

  typedef struct packed {
    in_t     pts;
    region_t rgn;
    wt_t     wa;
    wt_t     wb;
    wt_t     wc;
  } carry_t;

  carry_t c1_r, c2_r, c3_r, c4_r, c5_r, wts_c;
  logic signed [MUL_BITS-1:0]  m_r[3][3];
  logic signed [SUM_BITS-1:0]  s_r[3];
  logic signed [DD_BITS-1:0]   dd_r[3];
  logic signed [2*DD_BITS-1:0] sq_r[3];
  out_t res_r;
  logic [5:0] v_r;

  coord_t ca[3], cb[3], cc[3], cp[3];
  logic signed [SUM_BITS-1:0] bias[3], qv[3];
  logic [WEIGHT_BITS:0] wsum;

  assign ca[0] = c1_r.pts.corner_a_x; assign ca[1] = c1_r.pts.corner_a_y;
  assign ca[2] = c1_r.pts.corner_a_z;
  assign cb[0] = c1_r.pts.corner_b_x; assign cb[1] = c1_r.pts.corner_b_y;
  assign cb[2] = c1_r.pts.corner_b_z;
  assign cc[0] = c1_r.pts.corner_c_x; assign cc[1] = c1_r.pts.corner_c_y;
  assign cc[2] = c1_r.pts.corner_c_z;
  assign cp[0] = c3_r.pts.point_x;    assign cp[1] = c3_r.pts.point_y;
  assign cp[2] = c3_r.pts.point_z;

  assign wsum = {1'b0, q0_in} + {1'b0, q1_in};

  always_comb begin
    wts_c.pts = side_in.pts;
    wts_c.rgn = side_in.rgn;
    wts_c.wa  = WEIGHT_ONE;
    wts_c.wb  = '0;
    wts_c.wc  = '0;
    case (side_in.rgn)
      RGN_B: begin
        wts_c.wa = '0;
        wts_c.wb = WEIGHT_ONE;
      end
      RGN_AB: begin
        wts_c.wb = q0_in;
        wts_c.wa = WEIGHT_ONE - q0_in;
      end
      RGN_C: begin
        wts_c.wa = '0;
        wts_c.wc = WEIGHT_ONE;
      end
      RGN_AC: begin
        wts_c.wc = q1_in;
        wts_c.wa = WEIGHT_ONE - q1_in;
      end
      RGN_BC: begin
        wts_c.wa = '0;
        wts_c.wc = q1_in;
        wts_c.wb = WEIGHT_ONE - q1_in;
      end
      RGN_IN: begin
        wts_c.wb = q0_in;
        // clamp so the three weights never exceed one
        wts_c.wc = (wsum > {1'b0, WEIGHT_ONE}) ? WEIGHT_ONE - q0_in : q1_in;
        wts_c.wa = WEIGHT_ONE - wts_c.wb - wts_c.wc;
      end
      default: begin
        wts_c.wa = WEIGHT_ONE;
      end
    endcase
  end

  // truncate toward zero on the weighted sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bias[i] = s_r[i][SUM_BITS-1] ? SUM_BITS'(WEIGHT_ONE - 1'b1) : '0;
      qv[i]   = (s_r[i] + bias[i]) >>> WEIGHT_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= wts_c;
      for (int i = 0; i < 3; i++) begin
        m_r[i][0] <= ca[i] * $signed({1'b0, c1_r.wa});
        m_r[i][1] <= cb[i] * $signed({1'b0, c1_r.wb});
        m_r[i][2] <= cc[i] * $signed({1'b0, c1_r.wc});
        s_r[i]    <= SUM_BITS'(m_r[i][0]) + SUM_BITS'(m_r[i][1]) + SUM_BITS'(m_r[i][2]);
        dd_r[i]   <= DD_BITS'(cp[i]) - DD_BITS'(qv[i]);
        sq_r[i]   <= dd_r[i] * dd_r[i];
      end
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
      res_r.weight_a <= c5_r.wa;
      res_r.weight_b <= c5_r.wb;
      res_r.weight_c <= c5_r.wc;
      res_r.sq_dist  <= DIST_BITS'(sq_r[0] + sq_r[1] + sq_r[2]);
      res_r.region   <= c5_r.rgn;
    end
  end

  assign v_out   = v_r[5];
  assign res_out = res_r;

endmodule

[hdl/closest_point_on_triangle.sv]
// top level of the closest point on triangle pipeline
// Takes one query item per clock while the output is not stalled: a point and
// three triangle corners in signed Q12.12, and returns barycentric weights of
// the closest point on the triangle (Q1.16, 65536 is one), the squared
// distance in Q26.24 and a region code (vertex, edge, interior, or degenerate
// when the triangle has zero area and no vertex or edge test matches, in which
// case corner A is reported). The pipeline is 30 register stages deep: 3 for
// edge vectors and dot products, 5 for the split 52x52 region products and
// region select, 16 for the one-bit-per-stage edge ratio dividers, and 6 for
// weights, closest point and distance. A stalled output holds the whole
// pipeline in place.
`timescale 1ns / 1ps
module closest_point_on_triangle import clpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // global advance: the output register is free or is being drained
  logic en;

  logic  dots_v;
  in_t   dots_pts;
  dots_t dots;

  logic  rgn_v;
  side_t rgn_side;
  lane_t lane0, lane1;

  logic  div_v;
  side_t div_side;
  wt_t   q0, q1;

  assign en       = !out_valid || out_ready;
  // no item is taken while reset clears the valid bits
  assign in_ready = en && rst_n;

  // dot products of the edge vectors
  clpt_dots u_dots (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_valid),
    .pts_in   (in_data),
    .v_out    (dots_v),
    .pts_out  (dots_pts),
    .dots_out (dots)
  );

  // region products, region choice and ratio operands
  clpt_region u_region (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (dots_v),
    .pts_in    (dots_pts),
    .dots_in   (dots),
    .v_out     (rgn_v),
    .side_out  (rgn_side),
    .lane0_out (lane0),
    .lane1_out (lane1)
  );

  // two ratio lanes, interior needs both at once
  clpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (rgn_v),
    .side_in  (rgn_side),
    .lane0_in (lane0),
    .lane1_in (lane1),
    .v_out    (div_v),
    .side_out (div_side),
    .q0_out   (q0),
    .q1_out   (q1)
  );

  // weights, closest point and distance, ends in the output register
  clpt_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (div_v),
    .side_in (div_side),
    .q0_in   (q0),
    .q1_in   (q1),
    .v_out   (out_valid),
    .res_out (out_data)
  );

  // weights of every result add up to one
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((WEIGHT_BITS+2)'(out_data.weight_a) + (WEIGHT_BITS+2)'(out_data.weight_b)
                   + (WEIGHT_BITS+2)'(out_data.weight_c)) == (WEIGHT_BITS+2)'(WEIGHT_ONE))
    else $error("weights do not sum to one");

  // degenerate triangle falls back to corner A
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.region == RGN_DEG |->
      out_data.weight_a == WEIGHT_ONE && out_data.weight_b == '0 && out_data.weight_c == '0)
    else $error("degenerate result not at corner A");

  // vertex B region puts all weight on B
  a_vertex_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.region == RGN_B |-> out_data.weight_b == WEIGHT_ONE)
    else $error("vertex B result with wrong weight");

endmodule

[tb/clpt_checker.sv]
// checker for the closest point block: predicts each accepted query and compares results
`timescale 1ns / 1ps
module clpt_checker import clpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   errors,
  output int   pending
);

  localparam longint ONE = longint'(1) << WEIGHT_FRAC_BITS;

  out_t expected_results[$];

  function automatic logic signed [127:0] mul_wide(longint x, longint y);
    logic signed [127:0] wx, wy;
    wx = x;
    wy = y;
    return wx * wy;
  endfunction

  // floor(num * one / den), clamped to [0, one]
  function automatic longint edge_ratio(logic signed [127:0] num, logic signed [127:0] den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return ONE;
    return longint'((num <<< WEIGHT_FRAC_BITS) / den);
  endfunction

  function automatic out_t closest_point(in_t it);
    longint p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3];
    longint d1, d2, d3, d4, d5, d6, wa, wb, wc, q, d;
    logic signed [127:0] va, vb, vc, den;
    logic [63:0] sum_sq;
    region_t rg;
    out_t r;
    p[0] = it.point_x;    p[1] = it.point_y;    p[2] = it.point_z;
    a[0] = it.corner_a_x; a[1] = it.corner_a_y; a[2] = it.corner_a_z;
    b[0] = it.corner_b_x; b[1] = it.corner_b_y; b[2] = it.corner_b_z;
    c[0] = it.corner_c_x; c[1] = it.corner_c_y; c[2] = it.corner_c_z;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
    d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
    d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
    d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
    d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
    d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
    vc = mul_wide(d1, d4) - mul_wide(d3, d2);
    vb = mul_wide(d5, d2) - mul_wide(d1, d6);
    va = mul_wide(d3, d6) - mul_wide(d5, d4);
    wa = ONE; wb = 0; wc = 0;
    if (d1 <= 0 && d2 <= 0) begin
      rg = RGN_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      wa = 0; wb = ONE; rg = RGN_B;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      wb = edge_ratio(d1, d1 - d3);
      wa = ONE - wb; rg = RGN_AB;
    end else if (d6 >= 0 && d5 <= d6) begin
      wa = 0; wc = ONE; rg = RGN_C;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      wc = edge_ratio(d2, d2 - d6);
      wa = ONE - wc; rg = RGN_AC;
    end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
      wa = 0;
      wc = edge_ratio(d4 - d3, (d4 - d3) + (d5 - d6));
      wb = ONE - wc; rg = RGN_BC;
    end else begin
      den = va + vb + vc;
      if (den == 0) begin
        rg = RGN_DEG;
      end else begin
        wb = edge_ratio(vb, den);
        wc = edge_ratio(vc, den);
        if (wb + wc > ONE) wc = ONE - wb;
        wa = ONE - wb - wc;
        rg = RGN_IN;
      end
    end
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      q = (a[i]*wa + b[i]*wb + c[i]*wc) / ONE;
      d = p[i] - q;
      sum_sq += d * d;
    end
    r.weight_a = wt_t'(wa);
    r.weight_b = wt_t'(wb);
    r.weight_c = wt_t'(wc);
    r.sq_dist  = sum_sq[DIST_BITS-1:0];
    r.region   = rg;
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) expected_results.push_back(closest_point(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.weight_a != out_data.weight_a || exp_r.weight_b != out_data.weight_b ||
              exp_r.weight_c != out_data.weight_c || exp_r.region != out_data.region ||
              exp_r.sq_dist != out_data.sq_dist) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected wa=%0d wb=%0d wc=%0d dist=%0d rgn=%0d,",
                        " got wa=%0d wb=%0d wc=%0d dist=%0d rgn=%0d"},
                       exp_r.weight_a, exp_r.weight_b, exp_r.weight_c, exp_r.sq_dist,
                       exp_r.region, out_data.weight_a, out_data.weight_b,
                       out_data.weight_c, out_data.sq_dist, out_data.region);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/closest_point_on_triangle_tb.sv]
// testbench top for the closest point block: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module closest_point_on_triangle_tb;
  import clpt_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   errors, pending;
  int   cycles = 0;
  int   items_sent = 0;
  bit   stimulus_done = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  closest_point_on_triangle dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  clpt_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[closest_point_on_triangle] ERROR");
      $finish;
    end
  end

  // burst state of the sender
  int burst_left = 0;

  // present one item at the falling edge and hold it until accepted
  task automatic send_item(in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // some bursts follow straight on, others after a random gap
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic in_t make_item(int px, int py, int pz, int ax, int ay, int az,
                                    int bx, int by, int bz, int cx, int cy, int cz);
    in_t it;
    it.point_x = coord_t'(px);    it.point_y = coord_t'(py);    it.point_z = coord_t'(pz);
    it.corner_a_x = coord_t'(ax); it.corner_a_y = coord_t'(ay); it.corner_a_z = coord_t'(az);
    it.corner_b_x = coord_t'(bx); it.corner_b_y = coord_t'(by); it.corner_b_z = coord_t'(bz);
    it.corner_c_x = coord_t'(cx); it.corner_c_y = coord_t'(cy); it.corner_c_z = coord_t'(cz);
    return it;
  endfunction

  // signed offset within +-span
  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // small triangle near a random base with a point around it, so every region shows up
  function automatic in_t local_item();
    int base[3], span, pspan, k;
    int a[3], b[3], c[3], p[3];
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 4096;
      2: span = 1 << 16;
      default: span = 1 << 20;
    endcase
    pspan = 2 * span;
    for (int i = 0; i < 3; i++) begin
      base[i] = jitter(1 << 22);
      a[i] = base[i] + jitter(span);
      b[i] = base[i] + jitter(span);
      c[i] = base[i] + jitter(span);
      p[i] = base[i] + jitter(pspan);
    end
    // degenerate shapes: repeated corner or collinear corners
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k == 0) b[i] = a[i];
      if (k == 1) c[i] = a[i] + 2 * (b[i] - a[i]);
      if (k == 2) c[i] = b[i];
    end
    return make_item(p[0], p[1], p[2], a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
  endfunction

  function automatic in_t wild_item();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  // receiver: random stall pattern, one long hold-off while the sender keeps offering items
  initial begin
    int mode, run;
    bit held;
    held = 0;
    run  = 0;
    @(posedge rst_n);
    while (!stimulus_done || pending > 0) begin
      @(negedge clk);
      if (!held && items_sent >= 400) begin
        held = 1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(5, 60);
      end
      run--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        2: out_ready = ($urandom_range(0, 1) == 0);
        default: out_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
    out_ready = 1'b1;
  end

  localparam int MAXC = (1 << 23) - 1;
  localparam int MINC = -(1 << 23);

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: vertex, edge and interior regions on a right triangle in the xy plane
    send_item(make_item(-4096, -4096, 0,  0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(8192, -100, 50,   0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(1000, -3000, 7,   0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(-10, 9000, -9,    0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(-3000, 1234, 0,   0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(3000, 3000, 100,  0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    send_item(make_item(1000, 1000, -500, 0, 0, 0,  4096, 0, 0,  0, 4096, 0));
    // degenerate: all corners equal, collinear, zero-length edge
    send_item(make_item(5, 6, 7,          0, 0, 0,  0, 0, 0,  0, 0, 0));
    send_item(make_item(100, 900, 3,      0, 0, 0,  4096, 0, 0,  8192, 0, 0));
    send_item(make_item(100, -900, 3,     10, 10, 10,  10, 10, 10,  500, 20, 30));
    send_item(make_item(-50, 70, 3,       10, 10, 10,  300, 20, 10,  300, 20, 10));
    // extremes of the coordinate range
    send_item(make_item(MAXC, MAXC, MAXC, MINC, MINC, MINC,  MAXC, MINC, MINC,  MINC, MAXC, MINC));
    send_item(make_item(MINC, MINC, MINC, MAXC, MAXC, MAXC,  MINC, MAXC, MAXC,  MAXC, MINC, MAXC));
    send_item(make_item(0, 0, MAXC,       MINC, MINC, MINC,  MAXC, MINC, MINC,  MINC, MAXC, MINC));
    send_item(make_item(MINC, 0, MAXC,    MAXC, MINC, 0,  MINC, MAXC, 0,  MAXC, MAXC, MINC));
    send_item(make_item(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_item(make_item(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_item(make_item(MAXC, MINC, 0,    0, 0, 0,  1, 0, 0,  0, 1, 0));

    // random: mostly local triangles, some full-range noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) == 0) send_item(wild_item());
      else send_item(local_item());
    end
    in_valid = 1'b0;
    stimulus_done = 1;

    wait (pending == 0);
    // pipeline is 30 stages deep; let anything stray drain out
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[closest_point_on_triangle] OK");
    end else begin
      $display("[closest_point_on_triangle] ERROR");
    end
    $finish;
  end

endmodule
